@@ hw/rtl/escaped_frame_receiver_core_macros.svh @@
// Assertion macros used by the receiver's decode module.
`ifndef ESCAPED_FRAME_RECEIVER_CORE_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define EFR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define EFR_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define EFR_ASSERT(label, clk, rstn, prop, msg)
`define EFR_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

@@ hw/rtl/efr_pkg.sv @@
package efr_pkg;

    localparam logic [7:0] SYNC_CODE_RESET   = 8'hE0;
    localparam logic [7:0] ESCAPE_CODE_RESET = 8'hD0;

    localparam logic REG_SYNC_CODE   = 1'b0;
    localparam logic REG_ESCAPE_CODE = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_NODE = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BODY = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_ZERO = 2'd3
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic [7:0] node_addr;
        kind_t      kind;
        logic       last;
    } res_t;

endpackage

@@ hw/rtl/efr_decode.sv @@
`include "escaped_frame_receiver_core_macros.svh"

module efr_decode (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    raw_byte,
    input  logic [7:0]    sync_code,
    input  logic [7:0]    escape_code,
    output efr_pkg::res_t res
);

    efr_pkg::phase_t phase_reg, phase_next;
    logic            esc_reg, esc_next;
    logic [7:0]      node_reg, node_next;
    logic [7:0]      left_reg, left_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      dec_byte;

    assign dec_byte = esc_reg ? raw_byte + 8'd1 : raw_byte;

    always_comb begin
        phase_next    = phase_reg;
        esc_next      = esc_reg;
        node_next     = node_reg;
        left_next     = left_reg;
        sum_next      = sum_reg;
        res.valid     = 1'b0;
        res.data_byte = dec_byte;
        res.node_addr = node_reg;
        res.kind      = efr_pkg::KIND_BODY;
        res.last      = 1'b0;
        if (raw_byte == sync_code) begin
            phase_next = efr_pkg::PH_NODE;
            esc_next   = 1'b0;
        end else if (phase_reg != efr_pkg::PH_HUNT) begin
            if (raw_byte == escape_code) begin
                esc_next = 1'b1;
            end else begin
                esc_next = 1'b0;
                case (phase_reg)
                    efr_pkg::PH_NODE: begin
                        node_next  = dec_byte;
                        sum_next   = dec_byte;
                        phase_next = efr_pkg::PH_LEN;
                    end
                    efr_pkg::PH_LEN: begin
                        if (dec_byte == 8'd0) begin
                            phase_next    = efr_pkg::PH_HUNT;
                            res.valid     = 1'b1;
                            res.data_byte = 8'd0;
                            res.kind      = efr_pkg::KIND_ZERO;
                            res.last      = 1'b1;
                        end else begin
                            left_next  = dec_byte;
                            sum_next   = sum_reg + dec_byte;
                            phase_next = efr_pkg::PH_BODY;
                        end
                    end
                    efr_pkg::PH_BODY: begin
                        res.valid = 1'b1;
                        if (left_reg > 8'd1) begin
                            left_next = left_reg - 8'd1;
                            sum_next  = sum_reg + dec_byte;
                        end else begin
                            left_next  = 8'd0;
                            phase_next = efr_pkg::PH_HUNT;
                            res.kind   = (dec_byte == sum_reg) ? efr_pkg::KIND_GOOD
                                                               : efr_pkg::KIND_BAD;
                            res.last   = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = efr_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= efr_pkg::PH_HUNT;
            esc_reg   <= 1'b0;
            node_reg  <= 8'd0;
            left_reg  <= 8'd0;
            sum_reg   <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            node_reg  <= node_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
        end
    end

    `EFR_ASSERT_NEVER(a_no_result_while_hunting, aclk, aresetn, res.valid && phase_reg == efr_pkg::PH_HUNT, "result produced while hunting for sync")
    `EFR_ASSERT(a_end_returns_to_hunt, aclk, aresetn, step && res.valid && res.last |=> phase_reg == efr_pkg::PH_HUNT, "frame end did not return to hunting")
    `EFR_ASSERT(a_sync_restarts, aclk, aresetn, step && raw_byte == sync_code |=> phase_reg == efr_pkg::PH_NODE && !esc_reg, "sync byte did not restart the frame")
    `EFR_ASSERT_NEVER(a_body_last_consistent, aclk, aresetn, res.valid && (res.last == (res.kind == efr_pkg::KIND_BODY)), "last flag disagrees with kind")

endmodule

@@ hw/rtl/efr_out_stage.sv @@
module efr_out_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  efr_pkg::res_t res,
    input  logic          m_ready,
    output logic          free,
    output logic          m_valid,
    output logic [7:0]    m_data_byte,
    output logic [7:0]    m_node_addr,
    output logic [1:0]    m_kind,
    output logic          m_last
);

    logic          valid_reg, valid_next;
    efr_pkg::res_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        if (load && res.valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.valid) begin
            data_reg <= res;
        end
    end

    assign m_valid     = valid_reg;
    assign m_data_byte = data_reg.data_byte;
    assign m_node_addr = data_reg.node_addr;
    assign m_kind      = data_reg.kind;
    assign m_last      = data_reg.last;

endmodule

@@ hw/rtl/escaped_frame_receiver_core.sv @@
// Deframer for sync-delimited, escape-coded byte frames.
// Raw bytes enter on the s_ channel (s_valid, s_ready, s_rx_byte), one item per byte.
// Decoded body bytes and one frame-end verdict per completed frame leave on the m_ channel
// with the frame's node address, a kind code and a last flag.
// Bytes before the sync code, escape bytes and header bytes other than a zero length produce no item.
// The sync and escape codes are written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the block is idle (not enforced here). They reset to 0xE0 and 0xD0.
// An item accepted at one clock edge is held in the input register, decoded combinationally
// and loaded into the output register, which drives m_valid, once that register is free.
// One item is accepted in every cycle while the output is not stalled; the rate is set by the
// single decode stage between the input register and the output register.
// When the receiver stalls, the output register holds its item and the input
// register still takes one more byte; s_ready falls only when both are occupied.
// A synchronous reset on aresetn returns the block to hunting for sync, clears
// both registers' valid flags and restores the default codes.
module escaped_frame_receiver_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_node_addr,
    output logic [1:0] m_kind,
    output logic       m_last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic [7:0]    sync_code_reg;
    logic [7:0]    escape_code_reg;
    logic          out_free;
    logic          step;
    efr_pkg::res_t res;

    assign step    = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg && !out_free;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_code_reg   <= efr_pkg::SYNC_CODE_RESET;
            escape_code_reg <= efr_pkg::ESCAPE_CODE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                efr_pkg::REG_SYNC_CODE: begin
                    sync_code_reg <= cfg_data;
                end
                efr_pkg::REG_ESCAPE_CODE: begin
                    escape_code_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    efr_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .raw_byte    (in_byte_reg),
        .sync_code   (sync_code_reg),
        .escape_code (escape_code_reg),
        .res         (res)
    );

    efr_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (step),
        .res         (res),
        .m_ready     (m_ready),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_data_byte (m_data_byte),
        .m_node_addr (m_node_addr),
        .m_kind      (m_kind),
        .m_last      (m_last)
    );

endmodule

@@ verif/tb_escaped_frame_receiver_core.sv @@
`timescale 1ns / 1ps

module tb_escaped_frame_receiver_core;

    typedef struct {
        logic [7:0]     data;
        logic [7:0]     node;
        efr_pkg::kind_t kind;
        logic           last;
    } frame_result_t;

    class frame_scoreboard;
        logic [7:0]      sync_code;
        logic [7:0]      escape_code;
        efr_pkg::phase_t rx_state;
        bit              escape_seen;
        logic [7:0]      node_addr;
        logic [7:0]      remaining;
        logic [7:0]      checksum_acc;
        frame_result_t   expected_results[$];
        int              errors;

        function new();
            sync_code    = efr_pkg::SYNC_CODE_RESET;
            escape_code  = efr_pkg::ESCAPE_CODE_RESET;
            rx_state     = efr_pkg::PH_HUNT;
            escape_seen  = 1'b0;
            node_addr    = 8'h00;
            remaining    = 8'h00;
            checksum_acc = 8'h00;
            errors       = 0;
        endfunction

        function void set_register(logic index, logic [7:0] value);
            if (index == efr_pkg::REG_SYNC_CODE) begin
                sync_code = value;
            end else begin
                escape_code = value;
            end
        endfunction

        function void add_result(logic [7:0] data, efr_pkg::kind_t kind, logic last);
            frame_result_t r;
            r.data = data;
            r.node = node_addr;
            r.kind = kind;
            r.last = last;
            expected_results.push_back(r);
        endfunction

        function void note_byte(logic [7:0] raw);
            logic [7:0] decoded;
            if (raw == sync_code) begin
                rx_state    = efr_pkg::PH_NODE;
                escape_seen = 1'b0;
                return;
            end
            if (rx_state == efr_pkg::PH_HUNT) begin
                return;
            end
            if (raw == escape_code) begin
                escape_seen = 1'b1;
                return;
            end
            decoded     = escape_seen ? raw + 8'd1 : raw;
            escape_seen = 1'b0;
            case (rx_state)
                efr_pkg::PH_NODE: begin
                    node_addr    = decoded;
                    checksum_acc = decoded;
                    rx_state     = efr_pkg::PH_LEN;
                end
                efr_pkg::PH_LEN: begin
                    if (decoded == 8'h00) begin
                        rx_state = efr_pkg::PH_HUNT;
                        add_result(8'h00, efr_pkg::KIND_ZERO, 1'b1);
                    end else begin
                        remaining    = decoded;
                        checksum_acc = checksum_acc + decoded;
                        rx_state     = efr_pkg::PH_BODY;
                    end
                end
                default: begin
                    if (remaining > 8'd1) begin
                        remaining    = remaining - 8'd1;
                        checksum_acc = checksum_acc + decoded;
                        add_result(decoded, efr_pkg::KIND_BODY, 1'b0);
                    end else begin
                        remaining = 8'h00;
                        rx_state  = efr_pkg::PH_HUNT;
                        add_result(decoded, (decoded == checksum_acc) ? efr_pkg::KIND_GOOD
                                                                      : efr_pkg::KIND_BAD,
                                   1'b1);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) begin
                $display("[%0t] ERROR: %s", $realtime, msg);
            end
        endtask

        task check_result(logic [7:0] data, logic [7:0] node, logic [1:0] kind, logic last);
            frame_result_t e;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected item data=%02h node=%02h kind=%0d last=%b",
                                 data, node, kind, last));
                return;
            end
            e = expected_results.pop_front();
            if (data !== e.data) begin
                report($sformatf("data_byte got %02h, want %02h", data, e.data));
            end
            if (node !== e.node) begin
                report($sformatf("node_addr got %02h, want %02h", node, e.node));
            end
            if (kind !== e.kind) begin
                report($sformatf("kind got %0d, want %0d", kind, e.kind));
            end
            if (last !== e.last) begin
                report($sformatf("last got %b, want %b", last, e.last));
            end
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_data_byte;
    logic [7:0] m_node_addr;
    logic [1:0] m_kind;
    logic       m_last;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    frame_scoreboard sb;
    logic [7:0]      byte_stream[$];
    logic [7:0]      cur_sync;
    logic [7:0]      cur_escape;
    int              src_max_gap;
    int              sink_max_stall;

    escaped_frame_receiver_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_node_addr (m_node_addr),
        .m_kind      (m_kind),
        .m_last      (m_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready === 1'b1) begin
                sb.note_byte(s_rx_byte);
            end
            if (m_valid === 1'b1 && m_ready) begin
                sb.check_result(m_data_byte, m_node_addr, m_kind, m_last);
            end
        end
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = $urandom_range(0, sink_max_stall);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn === 1'b1 && m_valid === 1'b1));
        end
    end

    initial begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

    task send_byte(logic [7:0] value);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task send_stream();
        while (byte_stream.size() != 0) begin
            send_byte(byte_stream.pop_front());
        end
        s_valid <= 1'b0;
    endtask

    // The opening wait lets the monitor note the last accepted byte.
    task settle();
        repeat (2) @(posedge aclk);
        while (sb.expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
    endtask

    task write_reg(logic index, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        sb.set_register(index, value);
        cfg_we <= 1'b0;
        if (index == efr_pkg::REG_SYNC_CODE) begin
            cur_sync = value;
        end else begin
            cur_escape = value;
        end
        @(posedge aclk);
    endtask

    function bit is_code(logic [7:0] value);
        return value == cur_sync || value == cur_escape;
    endfunction

    // A value equal to a code goes out escaped; one that cannot be escaped goes out raw.
    function void push_coded(logic [7:0] value);
        logic [7:0] below;
        below = value - 8'd1;
        if (!is_code(value) && (is_code(below) || $urandom_range(0, 7) != 0)) begin
            byte_stream.push_back(value);
        end else if (!is_code(below)) begin
            byte_stream.push_back(cur_escape);
            if ($urandom_range(0, 5) == 0) begin
                byte_stream.push_back(cur_escape);
            end
            byte_stream.push_back(below);
        end else begin
            byte_stream.push_back(value);
        end
    endfunction

    function void push_frame(logic [7:0] len, bit corrupt);
        logic [7:0] node;
        logic [7:0] sum;
        logic [7:0] body;
        node = 8'($urandom_range(0, 255));
        sum  = node + len;
        byte_stream.push_back(cur_sync);
        push_coded(node);
        push_coded(len);
        if (len != 8'h00) begin
            for (int i = 1; i < len; i++) begin
                body = 8'($urandom_range(0, 255));
                sum  = sum + body;
                push_coded(body);
            end
            push_coded(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
        end
    endfunction

    function void push_random_unit();
        int         pick;
        logic [7:0] len;
        pick = $urandom_range(0, 19);
        if (pick <= 13) begin
            if ($urandom_range(0, 99) == 0) begin
                len = 8'($urandom_range(100, 255));
            end else begin
                len = 8'($urandom_range(1, 10));
            end
            push_frame(len, $urandom_range(0, 3) == 0);
        end else if (pick <= 15) begin
            repeat ($urandom_range(1, 6)) begin
                byte_stream.push_back(($urandom_range(0, 7) == 0) ? cur_escape
                                                                   : 8'($urandom_range(0, 255)));
            end
        end else if (pick == 16) begin
            len = 8'($urandom_range(3, 10));
            byte_stream.push_back(cur_sync);
            push_coded(8'($urandom_range(0, 255)));
            push_coded(len);
            repeat ($urandom_range(0, len - 2)) push_coded(8'($urandom_range(0, 255)));
        end else if (pick == 17) begin
            byte_stream.push_back(cur_sync);
            push_coded(8'($urandom_range(0, 255)));
            byte_stream.push_back(cur_escape);
            push_frame(8'($urandom_range(1, 6)), 1'b0);
        end else begin
            push_frame(8'h00, 1'b0);
        end
    endfunction

    initial begin
        logic [7:0] sync_values[7];
        logic [7:0] escape_values[7];
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_rx_byte      = 8'h00;
        cfg_we         = 1'b0;
        cfg_index      = efr_pkg::REG_SYNC_CODE;
        cfg_data       = 8'h00;
        cur_sync       = efr_pkg::SYNC_CODE_RESET;
        cur_escape     = efr_pkg::ESCAPE_CODE_RESET;
        src_max_gap    = 15;
        sink_max_stall = 15;
        sb = new();
        sync_values   = '{8'hE0, 8'h00, 8'hFF, 8'h5A, 8'h80, 8'h00, 8'hE0};
        escape_values = '{8'hD0, 8'hFF, 8'h00, 8'h5A, 8'h81, 8'h00, 8'hD0};
        sync_values[5]   = 8'($urandom_range(0, 255));
        escape_values[5] = 8'($urandom_range(0, 255));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        byte_stream = '{8'hD0, 8'hFF,
                        8'hE0, 8'hFF, 8'h01, 8'h00,
                        8'hE0, 8'h7F, 8'h00,
                        8'hE0, 8'h12, 8'hD0, 8'hE0,
                        8'h34, 8'h03, 8'hD0, 8'hD0, 8'hDF, 8'h0A, 8'h21,
                        8'hE0, 8'h00, 8'h02, 8'hFF, 8'h00};
        send_stream();
        settle();

        for (int p = 0; p < 7; p++) begin
            write_reg(efr_pkg::REG_SYNC_CODE, sync_values[p]);
            write_reg(efr_pkg::REG_ESCAPE_CODE, escape_values[p]);
            src_max_gap    = (p % 2 == 0) ? 15 : 0;
            sink_max_stall = (p % 4 < 2) ? 15 : 0;
            while (byte_stream.size() < 260) begin
                push_random_unit();
            end
            send_stream();
            settle();
        end

        if (sb.expected_results.size() != 0) begin
            sb.report($sformatf("%0d expected items never arrived",
                                sb.expected_results.size()));
        end
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
